// ===== rtl/core/mcls_pkg.sv =====
// ----------------------------------------------------------------------------
// mcls_pkg
// Shared types, widths and codes of the multi-chain LED level serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcls_pkg;

  localparam int CHAINS_DEF      = 4;
  localparam int LEDS_DEF        = 256;

  localparam int COLOR_W         = 24;
  localparam int COMP_W          = 8;
  localparam int MASK_W          = 32;
  localparam int DUR_W           = 20;
  localparam int PIN_W           = 5;
  localparam int CNT_W           = 9;
  localparam int FLAG_W          = 4;
  localparam int PINS_W          = 20;
  localparam int COUNTS_W        = 36;

  localparam int PULSES_PER_LED  = 16 * 3;
  localparam int PULSE_CNT_W     = 6;
  localparam int BIT_SEL_W       = 5;

  localparam int APB_ADDR_W      = 6;
  localparam int APB_DATA_W      = 64;
  localparam int REG_IDX_W       = 3;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EMIT  = 2'd1;
  localparam logic [1:0] CMD_LATCH = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_CHAIN_MODES   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_POL     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_POL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_PINS    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_PINS   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LED_COUNTS    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_WIDTH   = 3'd6;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [1:0]        chain_select;
    logic [7:0]        led_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] set_mask;
    logic [MASK_W-1:0] clear_mask;
    logic [DUR_W-1:0]  duration_us;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [FLAG_W-1:0]   chain_modes;
    logic [FLAG_W-1:0]   first_pol;
    logic [FLAG_W-1:0]   second_pol;
    logic [PINS_W-1:0]   first_pins;
    logic [PINS_W-1:0]   second_pins;
    logic [COUNTS_W-1:0] led_counts;
    logic [DUR_W-1:0]    pulse_width;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] hi_on;
    logic [MASK_W-1:0] hi_off;
    logic [MASK_W-1:0] lo_on;
    logic [MASK_W-1:0] lo_off;
    logic [MASK_W-1:0] mid_on;
    logic [MASK_W-1:0] mid_off;
  } levels_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_LATCH
  } state_e;

endpackage

// ===== rtl/core/multi_chain_led_level_serializer.sv =====
// ----------------------------------------------------------------------------
// multi_chain_led_level_serializer
// Colour store for several LED chains and serializer of GPIO level pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// After reset the block sweeps the colour store to zero, one entry a cycle,
// all CHAINS * LEDS_PER_CHAIN entries (1024 by default); no input word is
// taken meanwhile, register writes are. A write-colour word goes into the
// store on acceptance. An emit word first fetches the colour of each chain
// through the single read port of the store in ST_READ, and only then loads
// its first pulse word; it then puts out one pulse word a cycle, 48 in all,
// as fast as the output side takes them. A latch word gives its single
// pulse from ST_LATCH once the output register is free. The input stalls
// from the acceptance of an emit or latch word until its last pulse is
// loaded into the output register.

module multi_chain_led_level_serializer #(
  parameter int CHAINS         = mcls_pkg::CHAINS_DEF,
  parameter int LEDS_PER_CHAIN = mcls_pkg::LEDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mcls_pkg::in_word_t              in_word_i,
  // pulse words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mcls_pkg::out_word_t             out_word_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcls_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mcls_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mcls_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mcls_pkg::*;

  localparam int DEPTH = CHAINS * LEDS_PER_CHAIN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (CHAINS > 1) ? $clog2(CHAINS) : 1;   // chain index
  localparam int RCW   = $clog2(CHAINS + 1);                  // fetch counter
  localparam logic [PULSE_CNT_W-1:0] LAST_PULSE = PULSE_CNT_W'(PULSES_PER_LED - 1);
  localparam logic [CNT_W-1:0]       LEDS_CAP   = CNT_W'(LEDS_PER_CHAIN);

  // --- registers ------------------------------------------------------------
  cfg_t                            cfg_q, cfg_d;
  state_e                          state_q, state_d;
  logic [AW-1:0]                   clr_q, clr_d;
  logic [RCW-1:0]                  rd_cnt_q, rd_cnt_d;
  logic [PULSE_CNT_W-1:0]          pulse_q, pulse_d;
  logic [7:0]                      idx_q, idx_d;
  logic [CHAINS-1:0]               hit_q, hit_d;
  logic [CHAINS-1:0][COLOR_W-1:0]  col_q;
  logic                            out_valid_q, out_valid_d;
  out_word_t                       out_word_q, out_word_d;

  // --- datapath wires -------------------------------------------------------
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COLOR_W-1:0]    mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [COLOR_W-1:0]    mem_rdata;
  logic [CW-1:0]         rd_chain;
  logic [RCW-1:0]        rd_prev;
  logic [CHAINS-1:0]     hit_new;
  logic [8:0]            idx_ext;
  logic [CNT_W-1:0]      sel_cnt;
  logic                  wr_ok;
  logic [AW-1:0]         wr_addr;
  logic                  slot_free;
  logic [BIT_SEL_W-1:0]  bit_sel;
  logic [MASK_W-1:0]     data_set, data_clr, mid_set, mid_clr;
  logic                  cfg_wr;

  // --- register port --------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[APB_ADDR_W-1 -: REG_IDX_W])
        REG_CHAIN_MODES: cfg_d.chain_modes = pwdata[FLAG_W-1:0];
        REG_FIRST_POL:   cfg_d.first_pol   = pwdata[FLAG_W-1:0];
        REG_SECOND_POL:  cfg_d.second_pol  = pwdata[FLAG_W-1:0];
        REG_FIRST_PINS:  cfg_d.first_pins  = pwdata[PINS_W-1:0];
        REG_SECOND_PINS: cfg_d.second_pins = pwdata[PINS_W-1:0];
        REG_LED_COUNTS:  cfg_d.led_counts  = pwdata[COUNTS_W-1:0];
        REG_PULSE_WIDTH: cfg_d.pulse_width = pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_ADDR_W-1 -: REG_IDX_W])
      REG_CHAIN_MODES: prdata = APB_DATA_W'(cfg_q.chain_modes);
      REG_FIRST_POL:   prdata = APB_DATA_W'(cfg_q.first_pol);
      REG_SECOND_POL:  prdata = APB_DATA_W'(cfg_q.second_pol);
      REG_FIRST_PINS:  prdata = APB_DATA_W'(cfg_q.first_pins);
      REG_SECOND_PINS: prdata = APB_DATA_W'(cfg_q.second_pins);
      REG_LED_COUNTS:  prdata = APB_DATA_W'(cfg_q.led_counts);
      REG_PULSE_WIDTH: prdata = APB_DATA_W'(cfg_q.pulse_width);
      default:         prdata = '0;
    endcase
  end

  // --- index range checks ---------------------------------------------------
  // Effective count is the count field saturated at the chain capacity LEDS_PER_CHAIN.
  assign idx_ext = {1'b0, in_word_i.led_index};

  always_comb begin
    for (int c = 0; c < CHAINS; c++) begin
      hit_new[c] = (idx_ext < cfg_q.led_counts[CNT_W*c +: CNT_W]) && (idx_ext < LEDS_CAP);
    end
  end

  assign sel_cnt = cfg_q.led_counts[CNT_W*in_word_i.chain_select +: CNT_W];
  assign wr_ok   = ({1'b0, in_word_i.chain_select} < 3'(CHAINS)) &&
                   (idx_ext < sel_cnt) && (idx_ext < LEDS_CAP);
  assign wr_addr = AW'(in_word_i.chain_select) * AW'(LEDS_PER_CHAIN) +
                   AW'(in_word_i.led_index);

  // --- colour fetch: one chain per cycle, data lands the cycle after ------
  assign rd_chain  = rd_cnt_q[CW-1:0];
  assign rd_prev   = rd_cnt_q - RCW'(1);
  assign mem_raddr = hit_q[rd_chain] ?
                     (AW'(rd_chain) * AW'(LEDS_PER_CHAIN) + AW'(idx_q)) : '0;

  mcls_color_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // --- pulse unit -----------------------------------------------------------
  // Pulse order: blue, green, red, MSB first; even pulses carry data, odd
  // pulses return to mid level.
  assign bit_sel = {pulse_q[5:4], ~pulse_q[3:1]};

  mcls_pulse_unit #(
    .CHAINS (CHAINS)
  ) u_pulse (
    .cfg_i      (cfg_q),
    .colors_i   (col_q),
    .hit_i      (hit_q),
    .bit_sel_i  (bit_sel),
    .data_set_o (data_set),
    .data_clr_o (data_clr),
    .mid_set_o  (mid_set),
    .mid_clr_o  (mid_clr)
  );

  // --- sequencer ------------------------------------------------------------
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rd_cnt_d    = rd_cnt_q;
    pulse_d     = pulse_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.cmd)
            CMD_WRITE: begin
              if (wr_ok) begin
                mem_we    = 1'b1;
                mem_waddr = wr_addr;
                mem_wdata = {in_word_i.red, in_word_i.green, in_word_i.blue};
              end
            end
            CMD_EMIT: begin
              idx_d    = in_word_i.led_index;
              hit_d    = hit_new;
              rd_cnt_d = '0;
              state_d  = ST_READ;
            end
            CMD_LATCH: state_d = ST_LATCH;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (rd_cnt_q == RCW'(CHAINS)) begin
          pulse_d = '0;
          state_d = ST_EMIT;
        end else begin
          rd_cnt_d = rd_cnt_q + RCW'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_word_d.duration_us = cfg_q.pulse_width;
          if (!pulse_q[0]) begin
            out_word_d.set_mask   = data_set;
            out_word_d.clear_mask = data_clr;
            out_word_d.last       = 1'b0;
          end else begin
            out_word_d.set_mask   = mid_set;
            out_word_d.clear_mask = mid_clr;
            out_word_d.last       = (pulse_q == LAST_PULSE);
          end
          if (pulse_q == LAST_PULSE) begin
            state_d = ST_IDLE;
          end else begin
            pulse_d = pulse_q + PULSE_CNT_W'(1);
          end
        end
      end
      ST_LATCH: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_word_d.set_mask    = mid_set;
          out_word_d.clear_mask  = '0;
          out_word_d.duration_us = '0;
          out_word_d.last        = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cfg_q       <= '0;
      clr_q       <= '0;
      rd_cnt_q    <= '0;
      pulse_q     <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      clr_q       <= clr_d;
      rd_cnt_q    <= rd_cnt_d;
      pulse_q     <= pulse_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    out_word_q <= out_word_d;
    if (state_q == ST_READ && rd_cnt_q != '0) begin
      col_q[rd_prev[CW-1:0]] <= mem_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // --- assertions -----------------------------------------------------------
  a_emit_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.cmd == CMD_EMIT) |=> state_q == ST_READ)
    else $error("emit word did not start the colour fetch");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (in_stall_o && mem_we))
    else $error("store sweep not stalling input or not writing");

  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (rd_cnt_q <= RCW'(CHAINS)))
    else $error("fetch counter ran past the chain count");

  a_last_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && slot_free && pulse_q == LAST_PULSE) |=>
      (out_valid_q && out_word_q.last && state_q == ST_IDLE))
    else $error("final pulse not flagged last");

endmodule

// ===== rtl/core/mcls_color_mem.sv =====
// ----------------------------------------------------------------------------
// mcls_color_mem
// Single write port, single registered read port colour store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcls_color_mem #(
  parameter int DEPTH = mcls_pkg::CHAINS_DEF * mcls_pkg::LEDS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [mcls_pkg::COLOR_W-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [mcls_pkg::COLOR_W-1:0] rdata_o
);
  import mcls_pkg::*;

  logic [COLOR_W-1:0] mem_q [DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mcls_pulse_unit.sv =====
// ----------------------------------------------------------------------------
// mcls_pulse_unit
// Pin level decode per chain and the set/clear masks of one pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcls_pulse_unit #(
  parameter int CHAINS = mcls_pkg::CHAINS_DEF
) (
  input  mcls_pkg::cfg_t                         cfg_i,
  input  logic [CHAINS-1:0][mcls_pkg::COLOR_W-1:0] colors_i,
  input  logic [CHAINS-1:0]                      hit_i,
  input  logic [mcls_pkg::BIT_SEL_W-1:0]         bit_sel_i,
  output logic [mcls_pkg::MASK_W-1:0]            data_set_o,
  output logic [mcls_pkg::MASK_W-1:0]            data_clr_o,
  output logic [mcls_pkg::MASK_W-1:0]            mid_set_o,
  output logic [mcls_pkg::MASK_W-1:0]            mid_clr_o
);
  import mcls_pkg::*;

  levels_t lv [CHAINS];

  function automatic levels_t levels_of(input cfg_t cfg, input int c);
    levels_t t;
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] b;
    logic pa;
    logic pb;
    t  = '0;
    a  = MASK_W'(1) << cfg.first_pins[PIN_W*c +: PIN_W];
    b  = MASK_W'(1) << cfg.second_pins[PIN_W*c +: PIN_W];
    pa = cfg.first_pol[c];
    pb = cfg.second_pol[c];
    if (!cfg.chain_modes[c]) begin
      // two-pin alternative logic
      if (pa) begin
        t.hi_on |= a; t.mid_off |= a; t.lo_off |= a;
      end else begin
        t.hi_off |= a; t.mid_on |= a; t.lo_on |= a;
      end
      if (pb) begin
        t.hi_off |= b; t.mid_off |= b; t.lo_on |= b;
      end else begin
        t.hi_on |= b; t.mid_on |= b; t.lo_off |= b;
      end
    end else begin
      // tristate: second pin parks the line at mid level
      if (pa) begin
        t.hi_on |= a; t.lo_off |= a;
      end else begin
        t.hi_off |= a; t.lo_on |= a;
      end
      if (pb) begin
        t.hi_off |= b; t.mid_on |= b; t.lo_off |= b;
      end else begin
        t.hi_on |= b; t.mid_off |= b; t.lo_on |= b;
      end
    end
    return t;
  endfunction

  always_comb begin
    for (int c = 0; c < CHAINS; c++) begin
      lv[c] = levels_of(cfg_i, c);
    end
  end

  always_comb begin
    data_set_o = '0;
    data_clr_o = '0;
    mid_set_o  = '0;
    mid_clr_o  = '0;
    for (int c = 0; c < CHAINS; c++) begin
      mid_set_o |= lv[c].mid_on;
      mid_clr_o |= lv[c].mid_off;
      if (hit_i[c]) begin
        if (colors_i[c][bit_sel_i]) begin
          data_set_o |= lv[c].hi_on;
          data_clr_o |= lv[c].hi_off;
        end else begin
          data_set_o |= lv[c].lo_on;
          data_clr_o |= lv[c].lo_off;
        end
      end
    end
  end

endmodule

// ===== test/tb_multi_chain_led_level_serializer.sv =====
// ----------------------------------------------------------------------------
// tb_multi_chain_led_level_serializer
// Self-checking bench: drives command words and register writes, predicts
// every pulse word from its own color store and level tables, and compares
// the pulse stream word by word under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_chain_led_level_serializer;
  import mcls_pkg::*;

  localparam int NCH         = CHAINS_DEF;
  localparam int NLED        = LEDS_DEF;
  // Bound on the slowest legal run: ~260 words, each emit up to 48 pulses
  // with random receiver stalls on each, plus the store clear sweep.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_SHOWN   = 10;
  localparam int LONG_HOLD   = 400;  // receiver hold-off that backs up the block
  localparam int SETTLE      = 16;   // covers a color write still in flight
  localparam int TAIL        = 64;
  localparam int PHASE_WORDS = 40;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // unknown code, dropped by the block

  // --------------------------------------------------------------------------
  // Pulse predictor and scoreboard
  // --------------------------------------------------------------------------
  class pulse_scoreboard;
    cfg_t               cfg;
    logic [COLOR_W-1:0] led_colors [NCH*NLED];
    out_word_t          pulse_queue [$];
    int errors, pulses_ok, emits, latches, writes_kept, writes_dropped, words_seen;

    function new();
      cfg = '0;
      foreach (led_colors[i]) led_colors[i] = '0;
      errors = 0; pulses_ok = 0; emits = 0; latches = 0;
      writes_kept = 0; writes_dropped = 0; words_seen = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_CHAIN_MODES: cfg.chain_modes = value[FLAG_W-1:0];
        REG_FIRST_POL:   cfg.first_pol   = value[FLAG_W-1:0];
        REG_SECOND_POL:  cfg.second_pol  = value[FLAG_W-1:0];
        REG_FIRST_PINS:  cfg.first_pins  = value[PINS_W-1:0];
        REG_SECOND_PINS: cfg.second_pins = value[PINS_W-1:0];
        REG_LED_COUNTS:  cfg.led_counts  = value[COUNTS_W-1:0];
        REG_PULSE_WIDTH: cfg.pulse_width = value[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    // count field saturates at the chain capacity
    function int unsigned led_count(int c);
      logic [CNT_W-1:0] n;
      n = cfg.led_counts[CNT_W*c +: CNT_W];
      return (n > NLED) ? NLED : n;
    endfunction

    function levels_t chain_levels(int c);
      levels_t lv;
      logic [MASK_W-1:0] a, b;
      lv = '0;
      a = 32'd1 << cfg.first_pins[PIN_W*c +: PIN_W];
      b = 32'd1 << cfg.second_pins[PIN_W*c +: PIN_W];
      if (!cfg.chain_modes[c]) begin
        // two-pin alternative logic
        if (cfg.first_pol[c]) begin
          lv.hi_on |= a; lv.mid_off |= a; lv.lo_off |= a;
        end else begin
          lv.hi_off |= a; lv.mid_on |= a; lv.lo_on |= a;
        end
        if (cfg.second_pol[c]) begin
          lv.hi_off |= b; lv.mid_off |= b; lv.lo_on |= b;
        end else begin
          lv.hi_on |= b; lv.mid_on |= b; lv.lo_off |= b;
        end
      end else begin
        // tristate logic
        if (cfg.first_pol[c]) begin
          lv.hi_on |= a; lv.lo_off |= a;
        end else begin
          lv.hi_off |= a; lv.lo_on |= a;
        end
        if (cfg.second_pol[c]) begin
          lv.hi_off |= b; lv.mid_on |= b; lv.lo_off |= b;
        end else begin
          lv.hi_on |= b; lv.mid_off |= b; lv.lo_on |= b;
        end
      end
      return lv;
    endfunction

    function out_word_t make_pulse(logic [MASK_W-1:0] set_m, logic [MASK_W-1:0] clr_m,
                                   logic [DUR_W-1:0] dur, logic fin);
      out_word_t p;
      p.set_mask    = set_m;
      p.clear_mask  = clr_m;
      p.duration_us = dur;
      p.last        = fin;
      return p;
    endfunction

    // Called once per accepted input word; queues the pulses it must cause.
    function void note_input(in_word_t w);
      levels_t            lv [NCH];
      logic [MASK_W-1:0]  mid_on, mid_off, on, off;
      logic [COLOR_W-1:0] col;
      int                 c, comp, bp;
      mid_on  = '0;
      mid_off = '0;
      words_seen++;
      if (w.cmd == CMD_WRITE) begin
        if (w.chain_select < NCH && w.led_index < led_count(w.chain_select)) begin
          led_colors[w.chain_select*NLED + w.led_index] = {w.red, w.green, w.blue};
          writes_kept++;
        end else begin
          writes_dropped++;
        end
      end else if (w.cmd == CMD_EMIT || w.cmd == CMD_LATCH) begin
        for (c = 0; c < NCH; c++) begin
          lv[c] = chain_levels(c);
          mid_on  |= lv[c].mid_on;
          mid_off |= lv[c].mid_off;
        end
        if (w.cmd == CMD_LATCH) begin
          latches++;
          pulse_queue.push_back(make_pulse(mid_on, '0, '0, 1'b1));
        end else begin
          emits++;
          // blue, green, red; MSB first; data pulse then middle pulse
          for (comp = 0; comp < 3; comp++) begin
            for (bp = COMP_W-1; bp >= 0; bp--) begin
              on  = '0;
              off = '0;
              for (c = 0; c < NCH; c++) begin
                if (w.led_index < led_count(c)) begin
                  col = led_colors[c*NLED + w.led_index];
                  if (col[COMP_W*comp + bp]) begin
                    on |= lv[c].hi_on; off |= lv[c].hi_off;
                  end else begin
                    on |= lv[c].lo_on; off |= lv[c].lo_off;
                  end
                end
              end
              pulse_queue.push_back(make_pulse(on, off, cfg.pulse_width, 1'b0));
              pulse_queue.push_back(make_pulse(mid_on, mid_off, cfg.pulse_width,
                                               comp == 2 && bp == 0));
            end
          end
        end
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pulse_queue.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected pulse word: set %h clear %h dur %h last %b",
                   got.set_mask, got.clear_mask, got.duration_us, got.last);
        return;
      end
      want = pulse_queue.pop_front();
      if (got.set_mask !== want.set_mask || got.clear_mask !== want.clear_mask ||
          got.duration_us !== want.duration_us || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("pulse mismatch: exp set %h clear %h dur %h last %b",
                   want.set_mask, want.clear_mask, want.duration_us, want.last);
          $display("                got set %h clear %h dur %h last %b",
                   got.set_mask, got.clear_mask, got.duration_us, got.last);
        end
      end else begin
        pulses_ok++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals; every block input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // stall control shared between the main sequence and the receiver
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int burst_left   = 0;
  int cycles       = 0;

  pulse_scoreboard sb = new();

  multi_chain_led_level_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pulse words still due",
               cycles, sb.pulse_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each accepted pulse word, then picks the next stall.
  // A long hold-off is counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 9) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one word, optionally after an idle burst; returns in the time step
  // of the accepting edge with valid still high.
  task automatic send_word(input in_word_t w);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
  endtask

  // Setup then access cycle; psel is left high so writes can go back to back.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                           input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
  endtask

  task automatic program_config(input cfg_t c);
    reg_write(REG_CHAIN_MODES, APB_DATA_W'(c.chain_modes));
    reg_write(REG_FIRST_POL,   APB_DATA_W'(c.first_pol));
    reg_write(REG_SECOND_POL,  APB_DATA_W'(c.second_pol));
    reg_write(REG_FIRST_PINS,  APB_DATA_W'(c.first_pins));
    reg_write(REG_SECOND_PINS, APB_DATA_W'(c.second_pins));
    reg_write(REG_LED_COUNTS,  APB_DATA_W'(c.led_counts));
    reg_write(REG_PULSE_WIDTH, APB_DATA_W'(c.pulse_width));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, drain every due pulse, then let a trailing color write land.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pulse_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(logic [1:0] cmd, logic [1:0] sel, logic [7:0] idx,
                                         logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_word_t w;
    w.cmd = cmd; w.chain_select = sel; w.led_index = idx;
    w.red = r; w.green = g; w.blue = b;
    return w;
  endfunction

  function automatic in_word_t random_word();
    return make_word(2'($urandom_range(0, 3)), 2'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Counts lean to the corners: empty, single LED, full, over capacity.
  function automatic cfg_t random_cfg();
    cfg_t             c;
    logic [CNT_W-1:0] n;
    int               i;
    c.chain_modes = 4'($urandom);
    c.first_pol   = 4'($urandom);
    c.second_pol  = 4'($urandom);
    c.first_pins  = 20'($urandom);
    c.second_pins = 20'($urandom);
    c.pulse_width = 20'($urandom);
    c.led_counts  = '0;
    for (i = 0; i < NCH; i++) begin
      case ($urandom_range(0, 5))
        0:       n = '0;
        1:       n = 9'd1;
        2:       n = 9'(NLED);
        3:       n = '1;
        default: n = 9'($urandom_range(8, NLED));
      endcase
      c.led_counts[CNT_W*i +: CNT_W] = n;
    end
    return c;
  endfunction

  // Mostly well-formed: a few color writes to one LED of a small window,
  // then an emit of that LED, sometimes a latch. The rest is raw noise.
  task automatic run_phase(input int words);
    int       stop_at, base, idx;
    in_word_t w;
    stop_at = sb.words_seen + words;
    base    = $urandom_range(0, NLED - 8);
    while (sb.words_seen < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        idx = base + $urandom_range(0, 7);
        repeat ($urandom_range(1, 4)) begin
          w = random_word();
          w.cmd = CMD_WRITE;
          w.led_index = 8'(idx);
          send_word(w);
        end
        w = random_word();
        w.cmd = CMD_EMIT;
        w.led_index = 8'(idx);
        send_word(w);
        if ($urandom_range(0, 2) == 0) begin
          w = random_word();
          w.cmd = CMD_LATCH;
          send_word(w);
        end
      end else begin
        send_word(random_word());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   ph;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no chain holds any LED, so data pulses carry empty
    // masks and zero duration; the color write is dropped. Input words wait
    // out the store clear sweep on the stall.
    send_word(make_word(CMD_EMIT,  2'd0, 8'd0,   8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_LATCH, 2'd3, 8'd255, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_WRITE, 2'd0, 8'd0,   8'hFF, 8'hFF, 8'hFF));
    wait_idle();

    // Directed settings: mixed modes and polarities, distinct pins, and
    // counts of full, one, empty and over-capacity on chains 0..3.
    c.chain_modes = 4'b0101;
    c.first_pol   = 4'b0011;
    c.second_pol  = 4'b0110;
    c.first_pins  = {5'd31, 5'd20, 5'd10, 5'd0};
    c.second_pins = {5'd30, 5'd21, 5'd11, 5'd1};
    c.led_counts  = {9'd511, 9'd0, 9'd1, 9'd256};
    c.pulse_width = '1;
    program_config(c);

    send_word(make_word(CMD_WRITE,  2'd0, 8'd0,   8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_WRITE,  2'd0, 8'd255, 8'h80, 8'h01, 8'hFE));
    send_word(make_word(CMD_WRITE,  2'd1, 8'd0,   8'h00, 8'hFF, 8'h00));
    send_word(make_word(CMD_WRITE,  2'd1, 8'd1,   8'hAA, 8'hAA, 8'hAA)); // past count
    send_word(make_word(CMD_WRITE,  2'd2, 8'd0,   8'h55, 8'h55, 8'h55)); // empty chain
    send_word(make_word(CMD_WRITE,  2'd3, 8'd255, 8'h5A, 8'hC3, 8'h0F)); // saturated count
    send_word(make_word(CMD_EMIT,   2'd0, 8'd0,   8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_EMIT,   2'd2, 8'd255, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_EMIT,   2'd1, 8'd1,   8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_UNUSED, 2'd3, 8'd0,   8'hFF, 8'hFF, 8'hFF)); // dropped
    send_word(make_word(CMD_LATCH,  2'd0, 8'd0,   8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_WRITE,  2'd0, 8'd0,   8'h00, 8'h00, 8'h00)); // overwrite
    send_word(make_word(CMD_EMIT,   2'd3, 8'd0,   8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_EMIT,   2'd0, 8'd128, 8'h00, 8'h00, 8'h00)); // never written
    wait_idle();

    // Random phases, each under fresh settings written while idle.
    for (ph = 0; ph < 6; ph++) begin
      c = random_cfg();
      case (ph)
        0: c = '1;  // every field at its top: all chains on pin 31, counts saturate
        4: begin    // low corner of modes, polarities and duration
          c.chain_modes = '0;
          c.first_pol   = '0;
          c.second_pol  = '0;
          c.pulse_width = '0;
        end
        5: begin    // closing stretch runs without any idling
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end
        default: ;
      endcase
      program_config(c);
      if (ph == 2) hold_request = 1'b1;  // back the block up behind the receiver
      run_phase(PHASE_WORDS);
      wait_idle();
    end

    repeat (TAIL) @(posedge clk_i);

    $display("covered %0d emit and %0d latch words, %0d color writes kept, %0d dropped",
             sb.emits, sb.latches, sb.writes_kept, sb.writes_dropped);
    $display("%0d pulse words matched, %0d failures, %0d pulse words never seen",
             sb.pulses_ok, sb.errors, sb.pulse_queue.size());
    if (sb.errors == 0 && sb.pulse_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
